/* rtl/heap_sort_engine_defines.svh */
// assertion macros shared by the heap sort engine checkers
// depends on: nothing; expects i_clk and i_rst_n in the using scope
`ifndef HEAP_SORT_ENGINE_DEFINES_SVH
`define HEAP_SORT_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heap sort engine check failed");

// next-cycle implication, disabled in reset
`define HSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heap sort engine check failed");

`endif

/* rtl/hse_pkg.sv */
// heap sort engine package: microcode word types, opcodes, jump conditions, control store
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package hse_pkg;

    localparam int PC_W = 5;

    typedef logic [PC_W-1:0] t_pc;
    typedef logic [4:0]      t_op;
    typedef logic [3:0]      t_cond;

    // datapath operations
    localparam t_op OP_NOP     = 5'd0;
    localparam t_op OP_LOAD    = 5'd1;
    localparam t_op OP_BINIT   = 5'd2;
    localparam t_op OP_BSET    = 5'd3;
    localparam t_op OP_EINIT   = 5'd4;
    localparam t_op OP_RD_ROOT = 5'd5;
    localparam t_op OP_RD_END  = 5'd6;
    localparam t_op OP_SWAP    = 5'd7;
    localparam t_op OP_NODE_LD = 5'd8;
    localparam t_op OP_LEFT    = 5'd9;
    localparam t_op OP_PICK_L  = 5'd10;
    localparam t_op OP_PICK_R  = 5'd11;
    localparam t_op OP_MOVE    = 5'd12;
    localparam t_op OP_PUT     = 5'd13;
    localparam t_op OP_OINIT   = 5'd14;
    localparam t_op OP_ORD     = 5'd15;
    localparam t_op OP_EMIT    = 5'd16;

    // sequencing conditions
    localparam t_cond C_NEXT     = 4'd0;
    localparam t_cond C_JMP      = 4'd1;
    localparam t_cond C_NOT_FIN  = 4'd2;
    localparam t_cond C_K_ZERO   = 4'd3;
    localparam t_cond C_LC_OOB   = 4'd4;
    localparam t_cond C_RC_OOB   = 4'd5;
    localparam t_cond C_NOT_GT   = 4'd6;
    localparam t_cond C_NOT_LAST = 4'd7;
    localparam t_cond C_CALL     = 4'd8;
    localparam t_cond C_RET      = 4'd9;

    // step labels
    localparam t_pc L_IDLE   = 5'd0;
    localparam t_pc L_BINIT  = 5'd1;
    localparam t_pc L_BTEST  = 5'd2;
    localparam t_pc L_BSET   = 5'd3;
    localparam t_pc L_BLOOP  = 5'd4;
    localparam t_pc L_EINIT  = 5'd5;
    localparam t_pc L_ETEST  = 5'd6;
    localparam t_pc L_RDROOT = 5'd7;
    localparam t_pc L_RDEND  = 5'd8;
    localparam t_pc L_SWAP   = 5'd9;
    localparam t_pc L_ELOOP  = 5'd10;
    localparam t_pc L_OINIT  = 5'd11;
    localparam t_pc L_ORD    = 5'd12;
    localparam t_pc L_EMIT   = 5'd13;
    localparam t_pc L_DONE   = 5'd14;
    localparam t_pc L_SIFT   = 5'd15;
    localparam t_pc L_SLEFT  = 5'd16;
    localparam t_pc L_SPICKL = 5'd17;
    localparam t_pc L_SPICKR = 5'd18;
    localparam t_pc L_SCMP   = 5'd19;
    localparam t_pc L_SMOVE  = 5'd20;
    localparam t_pc L_SPUT   = 5'd21;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic fin;
        logic k_zero;
        logic lc_oob;
        logic rc_oob;
        logic not_gt;
        logic not_last;
    } t_flags;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_NOP, cond: C_JMP, target: L_IDLE};
        unique case (pc)
            L_IDLE:   w = '{op: OP_LOAD,    cond: C_NOT_FIN,  target: L_IDLE};
            L_BINIT:  w = '{op: OP_BINIT,   cond: C_NEXT,     target: L_IDLE};
            L_BTEST:  w = '{op: OP_NOP,     cond: C_K_ZERO,   target: L_EINIT};
            L_BSET:   w = '{op: OP_BSET,    cond: C_CALL,     target: L_SIFT};
            L_BLOOP:  w = '{op: OP_NOP,     cond: C_JMP,      target: L_BTEST};
            L_EINIT:  w = '{op: OP_EINIT,   cond: C_NEXT,     target: L_IDLE};
            L_ETEST:  w = '{op: OP_NOP,     cond: C_K_ZERO,   target: L_OINIT};
            L_RDROOT: w = '{op: OP_RD_ROOT, cond: C_NEXT,     target: L_IDLE};
            L_RDEND:  w = '{op: OP_RD_END,  cond: C_NEXT,     target: L_IDLE};
            L_SWAP:   w = '{op: OP_SWAP,    cond: C_CALL,     target: L_SIFT};
            L_ELOOP:  w = '{op: OP_NOP,     cond: C_JMP,      target: L_ETEST};
            L_OINIT:  w = '{op: OP_OINIT,   cond: C_NEXT,     target: L_IDLE};
            L_ORD:    w = '{op: OP_ORD,     cond: C_NEXT,     target: L_IDLE};
            L_EMIT:   w = '{op: OP_EMIT,    cond: C_NOT_LAST, target: L_ORD};
            L_DONE:   w = '{op: OP_NOP,     cond: C_JMP,      target: L_IDLE};
            L_SIFT:   w = '{op: OP_NODE_LD, cond: C_NEXT,     target: L_IDLE};
            L_SLEFT:  w = '{op: OP_LEFT,    cond: C_LC_OOB,   target: L_SPUT};
            L_SPICKL: w = '{op: OP_PICK_L,  cond: C_RC_OOB,   target: L_SCMP};
            L_SPICKR: w = '{op: OP_PICK_R,  cond: C_NEXT,     target: L_IDLE};
            L_SCMP:   w = '{op: OP_NOP,     cond: C_NOT_GT,   target: L_SPUT};
            L_SMOVE:  w = '{op: OP_MOVE,    cond: C_JMP,      target: L_SLEFT};
            L_SPUT:   w = '{op: OP_PUT,     cond: C_RET,      target: L_IDLE};
            default:  w = '{op: OP_NOP,     cond: C_JMP,      target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/hse_seq.sv */
// heap sort engine sequencer: step counter, one-level return register, control store lookup
// depends on: hse_pkg
`timescale 1ns / 1ps
`default_nettype none

module hse_seq import hse_pkg::*; (
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  wire t_flags i_flags,
    output t_uword o_uw
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_pc    r_ret;
    t_pc    n_ret;
    t_pc    pc_inc;
    t_uword uw;

    assign uw     = ucode(r_pc);
    assign pc_inc = r_pc + t_pc'(1);
    assign o_uw   = uw;

    always_comb begin
        n_pc  = pc_inc;
        n_ret = r_ret;
        unique case (uw.cond)
            C_NEXT:     n_pc = pc_inc;
            C_JMP:      n_pc = uw.target;
            C_NOT_FIN:  n_pc = i_flags.fin      ? pc_inc : uw.target;
            C_K_ZERO:   n_pc = i_flags.k_zero   ? uw.target : pc_inc;
            C_LC_OOB:   n_pc = i_flags.lc_oob   ? uw.target : pc_inc;
            C_RC_OOB:   n_pc = i_flags.rc_oob   ? uw.target : pc_inc;
            C_NOT_GT:   n_pc = i_flags.not_gt   ? uw.target : pc_inc;
            C_NOT_LAST: n_pc = i_flags.not_last ? uw.target : pc_inc;
            C_CALL: begin
                n_pc  = uw.target;
                n_ret = pc_inc;
            end
            C_RET:      n_pc = r_ret;
            default:    n_pc = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= L_IDLE;
            r_ret <= L_IDLE;
        end else begin
            r_pc  <= n_pc;
            r_ret <= n_ret;
        end
    end

endmodule

`default_nettype wire

/* rtl/heap_sort_engine.sv */
// heap sort engine top level: element memory, sift-down datapath, result registers
// depends on: hse_pkg, hse_seq
`timescale 1ns / 1ps
`default_nettype none

// Collects signed values one request per cycle while busy is low (start high accepts one).
// A request with i_last_in set, or the DEPTH-th request of a set, closes the set: busy rises
// and the set is heap sorted in place in the element memory, then emitted smallest first.
// Each result sits on o_value_out / o_last_out for exactly one cycle with o_strobe high;
// there is no way to hold results off, so the receiver must take every strobed cycle.
// o_last_out marks the largest, final value of the set. busy drops the cycle after it.
// The sort is run by a microcoded sequencer that makes at most one memory access per
// step: each sift-down level runs up to five steps (read left child, read right child,
// pick larger child, compare, move), skipping the pick of the right child when it lies
// outside the heap.
// The memory needs no clearing: reads from outside the current set are never used.

module heap_sort_engine import hse_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [DATA_WIDTH-1:0]  i_value_in,
    input  wire                          i_last_in,
    output logic                         o_strobe,
    output logic signed [DATA_WIDTH-1:0] o_value_out,
    output logic                         o_last_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // memory address width
    localparam int CW = $clog2(DEPTH + 1);                  // count width, holds DEPTH
    localparam int IW = AW + 2;                             // child index width

    t_uword uw;
    t_flags flags;

    // element memory
    logic [DATA_WIDTH-1:0]        r_mem [DEPTH];
    logic signed [DATA_WIDTH-1:0] r_rdata;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DATA_WIDTH-1:0]        wr_data;

    // control counters
    logic [CW-1:0] r_cnt;        // values loaded in current set
    logic [CW-1:0] r_n;          // size of set being sorted
    logic [CW-1:0] r_k;          // loop index, shared by build, extract and emit
    logic [CW-1:0] r_size;       // current heap size
    logic [CW-1:0] k_dec;
    logic [CW-1:0] n_dec;

    // sift-down datapath
    logic [AW-1:0]                r_node;
    logic [AW-1:0]                r_child;
    logic signed [DATA_WIDTH-1:0] r_val;    // value being sifted
    logic signed [DATA_WIDTH-1:0] r_cval;   // larger child so far, also swap temp
    logic [IW-1:0]                lc;
    logic [IW-1:0]                rc;
    logic [IW-1:0]                size_ext;

    // result registers
    logic                         r_strobe;
    logic                         r_last;
    logic signed [DATA_WIDTH-1:0] r_out;

    logic accept;
    logic fin;

    hse_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw)
    );

    assign busy     = (uw.op != OP_LOAD);
    assign accept   = start && !busy;
    // set closes on last mark or when the store fills
    assign fin      = accept && (i_last_in || (r_cnt == CW'(DEPTH - 1)));

    assign k_dec    = r_k - CW'(1);
    assign n_dec    = r_n - CW'(1);
    assign lc       = {1'b0, r_node, 1'b1};
    assign rc       = lc + IW'(1);
    assign size_ext = IW'(r_size);

    assign flags.fin      = fin;
    assign flags.k_zero   = (r_k == '0);
    assign flags.lc_oob   = (lc >= size_ext);
    assign flags.rc_oob   = (rc >= size_ext);
    assign flags.not_gt   = !(r_cval > r_val);
    assign flags.not_last = (r_k != n_dec);

    // memory port decode
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = r_cval;
        unique case (uw.op)
            OP_LOAD: begin
                wr_en   = accept;
                wr_addr = r_cnt[AW-1:0];
                wr_data = i_value_in;
            end
            OP_BSET: begin
                rd_en   = 1'b1;
                rd_addr = k_dec[AW-1:0];
            end
            OP_RD_ROOT: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            OP_RD_END, OP_ORD: begin
                rd_en   = 1'b1;
                rd_addr = r_k[AW-1:0];
            end
            OP_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = r_k[AW-1:0];
            end
            OP_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = lc[AW-1:0];     // out of range read is discarded
            end
            OP_PICK_L: begin
                rd_en   = 1'b1;
                rd_addr = rc[AW-1:0];
            end
            OP_MOVE: begin
                wr_en   = 1'b1;
                wr_addr = r_node;
            end
            OP_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_node;
                wr_data = r_val;
            end
            default: begin
                rd_en = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= $signed(r_mem[rd_addr]);
        end
    end

    // set bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= fin ? '0 : r_cnt + CW'(1);
        end
    end

    // datapath registers, loaded before use so no reset
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_n <= r_cnt + CW'(1);
        end
        unique case (uw.op)
            OP_BINIT: r_k <= r_n >> 1;
            OP_BSET: begin
                r_k    <= k_dec;
                r_node <= k_dec[AW-1:0];
                r_size <= r_n;
            end
            OP_EINIT:   r_k <= n_dec;
            OP_RD_END:  r_cval <= r_rdata;          // old root, written to the end next
            OP_SWAP: begin
                r_node <= '0;
                r_size <= r_k;
                r_k    <= k_dec;
            end
            OP_NODE_LD: r_val <= r_rdata;
            OP_PICK_L: begin
                r_child <= lc[AW-1:0];
                r_cval  <= r_rdata;
            end
            OP_PICK_R: begin
                if (r_rdata > r_cval) begin
                    r_child <= rc[AW-1:0];
                    r_cval  <= r_rdata;
                end
            end
            OP_MOVE:  r_node <= r_child;
            OP_OINIT: r_k <= '0;
            OP_EMIT: begin
                r_k   <= r_k + CW'(1);
                r_out <= r_rdata;
            end
            default: r_k <= r_k;
        endcase
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_strobe <= (uw.op == OP_EMIT);
            r_last   <= (uw.op == OP_EMIT) && !flags.not_last;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_last_out  = r_last;
    assign o_value_out = r_out;

endmodule

`default_nettype wire

/* rtl/hse_chk.sv */
// heap sort engine port checker and its bind to the top level
// depends on: heap_sort_engine_defines.svh, heap_sort_engine
`timescale 1ns / 1ps
`default_nettype none
`include "heap_sort_engine_defines.svh"

module hse_chk (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_start,
    input wire i_busy,
    input wire i_strobe,
    input wire i_last
);

    // results only come out of a closed set
    `HSE_ASSERT_IMP(a_strobe_busy, i_strobe, i_busy)
    // last flag never shows without a result
    `HSE_ASSERT_IMP(a_last_strobe, i_last, i_strobe)
    // final result frees the block for the next request
    `HSE_ASSERT_NXT(a_last_idle, i_strobe && i_last, !i_busy)
    // busy only starts from an accepted request
    `HSE_ASSERT_IMP(a_busy_cause, $rose(i_busy), $past(i_start))

endmodule

bind heap_sort_engine hse_chk u_hse_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_strobe (o_strobe),
    .i_last   (o_last_out)
);

`default_nettype wire
